>>> rtl/kms_pkg.sv
// Shared constants, types and helpers for the k-way merge selector.
`timescale 1ns / 1ps

package kms_pkg;

    localparam int MAX_RUNS   = 16;
    localparam int RUN_W      = 4;
    localparam int CNT_W      = 5;
    localparam int KEY_W      = 32;
    localparam int OFF_W      = 40;
    localparam int GROUP_SIZE = 4;
    localparam int NUM_GROUPS = MAX_RUNS / GROUP_SIZE;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [CNT_W-1:0] RUNS_RESET = CNT_W'(MAX_RUNS);

    // register index, taken from paddr[2]
    localparam logic REG_RUNS_IN_USE = 1'b0;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BUSY      = 2'd1;
    localparam logic [1:0] ST_EXHAUSTED = 2'd2;

    typedef struct packed {
        logic             vld;
        logic [KEY_W-1:0] key;
        logic [RUN_W-1:0] idx;
    } cand_t;

    typedef struct packed {
        logic load_item;
        logic commit;
        logic out_error;
        logic tree1_en;
        logic tree2_en;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic in_range;
        logic item_error;
        logic out_free;
        logic emit_ok;
        logic emit_last;
    } stat_t;

    // lower index sits in a, so ties keep a
    function automatic cand_t cand_pick(input cand_t a, input cand_t b);
        cand_t r;
        if (!a.vld)
            r = b;
        else if (b.vld && (b.key < a.key))
            r = b;
        else
            r = a;
        return r;
    endfunction

endpackage

>>> rtl/kms_if.sv
// Item channels: incoming run records and outgoing merge results.
`timescale 1ns / 1ps

interface kms_rec_if;
    logic                    valid;
    logic                    ready;
    logic [kms_pkg::RUN_W-1:0] run_index;
    logic [kms_pkg::KEY_W-1:0] record_key;
    logic [kms_pkg::OFF_W-1:0] record_offset;
    logic                    last_of_run;
    logic                    run_empty;

    modport source (
        output valid, run_index, record_key, record_offset, last_of_run, run_empty,
        input  ready
    );
    modport sink (
        input  valid, run_index, record_key, record_offset, last_of_run, run_empty,
        output ready
    );
endinterface

interface kms_res_if;
    logic                    valid;
    logic                    ready;
    logic [kms_pkg::KEY_W-1:0] out_key;
    logic [kms_pkg::OFF_W-1:0] out_offset;
    logic [kms_pkg::RUN_W-1:0] source_run;
    logic                    refill_wanted;
    logic                    merge_done;
    logic [1:0]              status;
    logic                    last_result;

    modport source (
        output valid, out_key, out_offset, source_run, refill_wanted, merge_done,
               status, last_result,
        input  ready
    );
    modport sink (
        input  valid, out_key, out_offset, source_run, refill_wanted, merge_done,
               status, last_result,
        output ready
    );
endinterface

>>> rtl/kms_ctrl.sv
// Sequencing state machine for the merge selector.
`timescale 1ns / 1ps

module kms_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           rec_valid,
    output logic           rec_ready,
    input  kms_pkg::stat_t stat,
    output kms_pkg::cmd_t  cmd
);
    import kms_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECIDE = 3'd1;
    localparam logic [2:0] S_TREE1  = 3'd2;
    localparam logic [2:0] S_TREE2  = 3'd3;
    localparam logic [2:0] S_EMIT   = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        rec_ready  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                rec_ready = 1'b1;
                if (rec_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (!stat.in_range)
                    state_next = S_IDLE;
                else if (stat.item_error)
                begin
                    if (stat.out_free)
                    begin
                        cmd.out_error = 1'b1;
                        state_next    = S_IDLE;
                    end
                end
                else
                begin
                    cmd.commit = 1'b1;
                    state_next = S_TREE1;
                end
            end
            S_TREE1:
            begin
                cmd.tree1_en = 1'b1;
                state_next   = S_TREE2;
            end
            S_TREE2:
            begin
                cmd.tree2_en = 1'b1;
                state_next   = S_EMIT;
            end
            S_EMIT:
            begin
                if (!stat.emit_ok)
                    state_next = S_IDLE;
                else if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = stat.emit_last ? S_IDLE : S_TREE1;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

endmodule

>>> rtl/kms_datapath.sv
// Head slots, run flags, two-stage minimum tree and result register.
`timescale 1ns / 1ps

module kms_datapath (
    input  logic                      clk,
    input  logic                      rst_n,
    input  kms_pkg::cmd_t             cmd,
    output kms_pkg::stat_t            stat,
    input  logic [kms_pkg::CNT_W-1:0] live_runs,
    input  logic [kms_pkg::RUN_W-1:0] run_index,
    input  logic [kms_pkg::KEY_W-1:0] record_key,
    input  logic [kms_pkg::OFF_W-1:0] record_offset,
    input  logic                      last_of_run,
    input  logic                      run_empty,
    kms_res_if.source                 results
);
    import kms_pkg::*;

    // latched item
    logic [RUN_W-1:0] it_run_reg;
    logic [KEY_W-1:0] it_key_reg;
    logic [OFF_W-1:0] it_off_reg;
    logic             it_last_reg;
    logic             it_empty_reg;

    // per-run state
    logic [KEY_W-1:0]    head_key_reg [MAX_RUNS];
    logic [OFF_W-1:0]    head_off_reg [MAX_RUNS];
    logic [MAX_RUNS-1:0] head_valid_reg;
    logic [MAX_RUNS-1:0] head_last_reg;
    logic [MAX_RUNS-1:0] exhausted_reg;

    // min tree
    cand_t            leaf [MAX_RUNS];
    cand_t            grp_next [NUM_GROUPS];
    cand_t            grp_reg [NUM_GROUPS];
    cand_t            best_next;
    logic [RUN_W-1:0] best_idx_reg;

    // result register
    logic             out_valid_reg;
    logic [KEY_W-1:0] out_key_reg;
    logic [OFF_W-1:0] out_off_reg;
    logic [RUN_W-1:0] out_run_reg;
    logic             out_refill_reg;
    logic             out_done_reg;
    logic [1:0]       out_status_reg;
    logic             out_lastres_reg;

    logic [MAX_RUNS-1:0] live;
    logic [MAX_RUNS-1:0] exh_after;
    logic                best_is_last;
    logic                done_after;

    always_comb
    begin
        for (int i = 0; i < MAX_RUNS; i++)
        begin
            live[i]     = CNT_W'(i) < live_runs;
            leaf[i].vld = head_valid_reg[i] & live[i] & ~exhausted_reg[i];
            leaf[i].key = head_key_reg[i];
            leaf[i].idx = RUN_W'(i);
        end
    end

    always_comb
    begin
        for (int g = 0; g < NUM_GROUPS; g++)
            grp_next[g] = cand_pick(cand_pick(leaf[GROUP_SIZE*g], leaf[GROUP_SIZE*g+1]),
                                    cand_pick(leaf[GROUP_SIZE*g+2], leaf[GROUP_SIZE*g+3]));
        best_next = cand_pick(cand_pick(grp_reg[0], grp_reg[1]),
                              cand_pick(grp_reg[2], grp_reg[3]));
    end

    assign best_is_last = head_last_reg[best_idx_reg];

    always_comb
    begin
        exh_after = exhausted_reg;
        if (best_is_last)
            exh_after[best_idx_reg] = 1'b1;
    end

    assign done_after = &(exh_after | ~live);

    assign stat.in_range   = {1'b0, it_run_reg} < live_runs;
    assign stat.item_error = exhausted_reg[it_run_reg] | head_valid_reg[it_run_reg];
    assign stat.out_free   = ~out_valid_reg | results.ready;
    assign stat.emit_ok    = (&(exhausted_reg | head_valid_reg | ~live))
                             & (|(live & ~exhausted_reg));
    assign stat.emit_last  = ~best_is_last | done_after;

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            it_run_reg   <= run_index;
            it_key_reg   <= record_key;
            it_off_reg   <= record_offset;
            it_last_reg  <= last_of_run;
            it_empty_reg <= run_empty;
        end
        if (cmd.commit && !it_empty_reg)
        begin
            head_key_reg[it_run_reg] <= it_key_reg;
            head_off_reg[it_run_reg] <= it_off_reg;
        end
        if (cmd.tree1_en)
            grp_reg <= grp_next;
        if (cmd.tree2_en)
            best_idx_reg <= best_next.idx;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= '0;
            head_last_reg  <= '0;
            exhausted_reg  <= '0;
        end
        else
        begin
            if (cmd.commit)
            begin
                if (it_empty_reg)
                    exhausted_reg[it_run_reg] <= 1'b1;
                else
                begin
                    head_valid_reg[it_run_reg] <= 1'b1;
                    head_last_reg[it_run_reg]  <= it_last_reg;
                end
            end
            if (cmd.emit)
            begin
                head_valid_reg[best_idx_reg] <= 1'b0;
                exhausted_reg                <= exh_after;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit || cmd.out_error)
            out_valid_reg <= 1'b1;
        else if (results.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_key_reg     <= head_key_reg[best_idx_reg];
            out_off_reg     <= head_off_reg[best_idx_reg];
            out_run_reg     <= best_idx_reg;
            out_refill_reg  <= ~best_is_last;
            out_done_reg    <= done_after;
            out_status_reg  <= ST_OK;
            out_lastres_reg <= ~best_is_last | done_after;
        end
        else if (cmd.out_error)
        begin
            out_key_reg     <= '0;
            out_off_reg     <= '0;
            out_run_reg     <= it_run_reg;
            out_refill_reg  <= 1'b0;
            out_done_reg    <= 1'b0;
            out_status_reg  <= exhausted_reg[it_run_reg] ? ST_EXHAUSTED : ST_BUSY;
            out_lastres_reg <= 1'b1;
        end
    end

    assign results.valid         = out_valid_reg;
    assign results.out_key       = out_key_reg;
    assign results.out_offset    = out_off_reg;
    assign results.source_run    = out_run_reg;
    assign results.refill_wanted = out_refill_reg;
    assign results.merge_done    = out_done_reg;
    assign results.status        = out_status_reg;
    assign results.last_result   = out_lastres_reg;

endmodule

>>> rtl/kway_merge_selector_unit.sv
// Merge selector for up to sixteen sorted runs: one record item in, zero or more results out.
// Records are taken one at a time. An accepted record is checked in the following cycle;
// a busy or exhausted slot gives its error result once the result port is free, or a record
// for a run at or above the clamped runs_in_use count is dropped and the block is ready again. A
// stored record is followed by a two-stage registered minimum tree over the sixteen head slots
// (group registers, then the best index register) and then the emit state. Emission repeats
// while the emitted record closed its run, some live run is not yet exhausted and every such
// run holds a head. A stalled result port holds the controller in its decide or emit state;
// the result register itself lets a record be accepted while a result waits.
`timescale 1ns / 1ps

module kway_merge_selector_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [kms_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [kms_pkg::APB_DATA_W-1:0] pwdata,
    output logic [kms_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    kms_rec_if.sink                        records,
    kms_res_if.source                      results
);
    import kms_pkg::*;

    logic [CNT_W-1:0] runs_in_use_reg;
    logic [CNT_W-1:0] live_runs;
    logic             reg_hit;
    cmd_t             cmd;
    stat_t            stat;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[2] == REG_RUNS_IN_USE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            runs_in_use_reg <= RUNS_RESET;
        else if (psel && penable && pwrite && pready && reg_hit)
            runs_in_use_reg <= pwdata[CNT_W-1:0];
    end

    assign prdata = reg_hit ? {{(APB_DATA_W-CNT_W){1'b0}}, runs_in_use_reg} : '0;

    // zero acts as one run, anything past the slot count as all slots
    always_comb
    begin
        if (runs_in_use_reg == '0)
            live_runs = CNT_W'(1);
        else if (runs_in_use_reg > CNT_W'(MAX_RUNS))
            live_runs = CNT_W'(MAX_RUNS);
        else
            live_runs = runs_in_use_reg;
    end

    kms_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .rec_valid (records.valid),
        .rec_ready (records.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    kms_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .live_runs     (live_runs),
        .run_index     (records.run_index),
        .record_key    (records.record_key),
        .record_offset (records.record_offset),
        .last_of_run   (records.last_of_run),
        .run_empty     (records.run_empty),
        .results       (results)
    );

`ifndef SYNTHESIS
    a_one_record_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        records.valid && records.ready |=> !records.ready)
        else $error("record accepted while previous one still in flight");

    a_refill_closes_item: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.refill_wanted |->
            results.last_result && (results.status == ST_OK))
        else $error("refill request not on final ok result");

    a_done_closes_item: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.merge_done |->
            results.last_result && !results.refill_wanted)
        else $error("merge done not on final result");

    a_no_result_while_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && !$past(results.valid) |-> !records.ready || $past(!records.ready))
        else $error("result appeared without an item in flight");
`endif

endmodule
